// ===== rtl/sitda_pkg.sv =====
`timescale 1ns / 1ps

package sitda_pkg;

    // ascii codes, trimmed to the 6-bit character field
    localparam logic [5:0] CH_ZERO  = 6'd48;
    localparam logic [5:0] CH_MINUS = 6'd45;
    localparam logic [5:0] CH_NINE  = 6'd57;

    localparam int DIGIT_BITS = 4;

    // handover from the converter to the character sender
    typedef struct packed {
        logic valid;
        logic neg;
    } sitda_hand_t;

endpackage

// ===== rtl/sitda_if.sv =====
`timescale 1ns / 1ps

interface sitda_num_if #(parameter int WIDTH = 32) ();
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sitda_char_if ();
    logic       valid;
    logic       ready;
    logic [5:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ===== rtl/signed_int_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// sequence: accept, one shift-add-3 step per magnitude bit, handover, then the sign,
// a leading-zero skip of up to DIGITS-1 digits and one character per cycle unless the receiver stalls
// the bit-serial converter sets the rate unless the receiver stalls; it takes the next number
// while the previous text drains
// reset: rst_n asynchronous, active low, clears control and output valid; no memories to sweep
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
#(
    parameter int INPUT_WIDTH = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    sitda_num_if.sink    number,
    sitda_char_if.source chars
);

    // decimal digits in the largest magnitude, 2^(INPUT_WIDTH-1)
    localparam int DIGITS = ((INPUT_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int BW     = DIGIT_BITS * DIGITS;

    logic                   dab_busy;
    logic                   start;
    logic                   neg;
    logic [INPUT_WIDTH-1:0] mag;
    logic                   take;
    logic [BW-1:0]          bcd;
    sitda_hand_t            hand;

    // a new word is taken whenever the converter is free, even while text drains
    assign number.ready = !dab_busy;
    assign start        = number.valid && number.ready;

    // magnitude: the most negative value negates to itself, read as unsigned it is exact
    assign neg = number.value[INPUT_WIDTH-1];
    assign mag = neg ? (~number.value + 1'b1) : number.value;

    // bit-serial double dabble, one magnitude bit per cycle into the bcd shift register
    sitda_dabble #(
        .WIDTH  (INPUT_WIDTH),
        .DIGITS (DIGITS)
    ) u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .neg   (neg),
        .mag   (mag),
        .busy  (dab_busy),
        .hand  (hand),
        .take  (take),
        .bcd   (bcd)
    );

    // character sender: sign, leading zero skip, then one digit per word
    sitda_emit #(
        .DIGITS (DIGITS)
    ) u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .hand  (hand),
        .bcd   (bcd),
        .take  (take),
        .chars (chars)
    );

endmodule

// ===== rtl/sitda_dabble.sv =====
`timescale 1ns / 1ps

module sitda_dabble
    import sitda_pkg::*;
#(
    parameter int WIDTH  = 32,
    parameter int DIGITS = 10
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         neg,
    input  logic [WIDTH-1:0]             mag,
    output logic                         busy,
    output sitda_hand_t                  hand,
    input  logic                         take,
    output logic [DIGIT_BITS*DIGITS-1:0] bcd
);

    localparam int CW = $clog2(WIDTH);
    localparam int BW = DIGIT_BITS * DIGITS;

    typedef enum logic [2:0] {
        D_IDLE  = 3'b001,
        D_SHIFT = 3'b010,
        D_HOLD  = 3'b100
    } dab_state_t;

    dab_state_t        state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [WIDTH-1:0]  mag_reg, mag_next;
    logic [BW-1:0]     bcd_reg, bcd_next;
    logic              neg_reg, neg_next;
    logic [BW-1:0]     adj;

    // add 3 to every digit of five or more before the shift
    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd_reg[d*DIGIT_BITS +: DIGIT_BITS] >= 4'd5)
                adj[d*DIGIT_BITS +: DIGIT_BITS] = bcd_reg[d*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
            else
                adj[d*DIGIT_BITS +: DIGIT_BITS] = bcd_reg[d*DIGIT_BITS +: DIGIT_BITS];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    mag_next   = mag;
                    bcd_next   = '0;
                    neg_next   = neg;
                    cnt_next   = '0;
                    state_next = D_SHIFT;
                end
            end
            D_SHIFT:
            begin
                bcd_next = {adj[BW-2:0], mag_reg[WIDTH-1]};
                mag_next = {mag_reg[WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(WIDTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = D_HOLD;
                end
            end
            D_HOLD:
            begin
                if (take)
                    state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    assign busy       = (state_reg != D_IDLE);
    assign hand.valid = (state_reg == D_HOLD);
    assign hand.neg   = neg_reg;
    assign bcd        = bcd_reg;

    // a finished conversion has consumed every magnitude bit
    a_hold_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == D_HOLD) |-> (cnt_reg == '0))
        else $error("converter holds a result with the bit counter not cleared");

endmodule

// ===== rtl/sitda_emit.sv =====
`timescale 1ns / 1ps

module sitda_emit
    import sitda_pkg::*;
#(
    parameter int DIGITS = 10
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  sitda_hand_t                  hand,
    input  logic [DIGIT_BITS*DIGITS-1:0] bcd,
    output logic                         take,
    sitda_char_if.source                 chars
);

    localparam int BW = DIGIT_BITS * DIGITS;
    localparam int LW = $clog2(DIGITS + 1);

    typedef enum logic [3:0] {
        E_IDLE  = 4'b0001,
        E_SIGN  = 4'b0010,
        E_SKIP  = 4'b0100,
        E_DIGIT = 4'b1000
    } emit_state_t;

    emit_state_t           state_reg, state_next;
    logic [LW-1:0]         left_reg, left_next;
    logic [BW-1:0]         digits_reg, digits_next;
    logic                  valid_reg, valid_next;
    logic [5:0]            char_reg, char_next;
    logic                  last_reg, last_next;
    logic [DIGIT_BITS-1:0] top;
    logic                  out_free;

    assign top      = digits_reg[BW-1 -: DIGIT_BITS];
    assign out_free = !valid_reg || chars.ready;
    assign take     = hand.valid && (state_reg == E_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        left_next   = left_reg;
        digits_next = digits_reg;
        valid_next  = valid_reg && !chars.ready;
        char_next   = char_reg;
        last_next   = last_reg;
        unique case (state_reg)
            E_IDLE:
            begin
                if (hand.valid)
                begin
                    digits_next = bcd;
                    left_next   = LW'(DIGITS);
                    state_next  = hand.neg ? E_SIGN : E_SKIP;
                end
            end
            E_SIGN:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    char_next  = CH_MINUS;
                    last_next  = 1'b0;
                    state_next = E_SKIP;
                end
            end
            E_SKIP:
            begin
                // drop leading zeros, keeping at least the units digit
                if ((top == '0) && (left_reg > LW'(1)))
                begin
                    digits_next = {digits_reg[BW-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
                    left_next   = left_reg - 1'b1;
                end
                else
                begin
                    state_next = E_DIGIT;
                end
            end
            E_DIGIT:
            begin
                if (out_free)
                begin
                    valid_next  = 1'b1;
                    char_next   = CH_ZERO + {2'b00, top};
                    last_next   = (left_reg == LW'(1));
                    digits_next = {digits_reg[BW-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
                    left_next   = left_reg - 1'b1;
                    if (left_reg == LW'(1))
                        state_next = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            left_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign chars.valid     = valid_reg;
    assign chars.char_code = char_reg;
    assign chars.last      = last_reg;

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((char_reg == CH_MINUS) ||
                       ((char_reg >= CH_ZERO) && (char_reg <= CH_NINE))))
        else $error("character outside minus and digits");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (char_reg == CH_MINUS)) |-> !last_reg)
        else $error("minus sign flagged as last character");

    a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == E_SKIP) || (state_reg == E_DIGIT)) |-> (left_reg != '0))
        else $error("sending digits with none left");

endmodule
